// File: hdl/acbp_pkg.sv
// ----------------------------------------------------------------------------
// acbp_pkg
// shared constants, tables and types for the arc curvature block
// ----------------------------------------------------------------------------
package acbp_pkg;

    localparam int DEF_COORD_WIDTH     = 32;
    localparam int DEF_COORD_FRAC_BITS = 16;
    localparam int DEF_ANGLE_WIDTH     = 32;

    // q30 angle and sine datapath widths
    localparam int ANG_W       = 36;
    localparam int RED_W       = 33;
    localparam int X_W         = 33;
    localparam int X2_W        = 32;
    localparam int T_W         = 31;
    localparam int P_W         = 33;
    localparam int QE_W        = 31;
    localparam int RECIP_SHIFT = 33;
    localparam int RECIP_W     = 31;
    localparam int DIV_W       = 8;
    localparam int SIN_W       = 34;
    localparam int TERMS       = 7;
    localparam int SINE_LAT    = 3 + 3 * TERMS + 1;

    localparam int Q_DEPTH     = 4;

    localparam logic signed [ANG_W-1:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30  = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30   = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] THREE_PI_Q30 = 36'sd10119778278;
    localparam logic signed [ANG_W-1:0] FOUR_PI_Q30  = 36'sd13493037704;

    localparam logic [T_W-1:0] Q30_ONE = 31'd1073741824;

    typedef logic [DIV_W-1:0]   tdiv_t;
    typedef logic [RECIP_W-1:0] recip_t;

    // horner divisors and floor(2^33 / divisor)
    localparam tdiv_t TAYLOR_DIV [TERMS] = '{
        8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam recip_t TAYLOR_RECIP [TERMS] = '{
        31'd40904450, 31'd55063683, 31'd78090314, 31'd119304647,
        31'd204522252, 31'd429496729, 31'd1431655765
    };

    typedef struct packed {
        logic neg;
        logic coincident;
    } acbp_flags_t;

endpackage

// File: hdl/acbp_sine.sv
// ----------------------------------------------------------------------------
// acbp_sine
// pipelined q30 sine: range reduction, fold, seven-step horner series
// ----------------------------------------------------------------------------
module acbp_sine (
    input  logic                                clk,
    input  logic signed [acbp_pkg::ANG_W-1:0]   angle,
    output logic signed [acbp_pkg::SIN_W-1:0]   sine
);
    import acbp_pkg::*;

    localparam int NS = 3 * TERMS + 1;

    logic signed [ANG_W-1:0] offset;
    logic signed [ANG_W-1:0] a_sum;
    logic signed [RED_W-1:0] a_red_reg;
    logic signed [X_W-1:0]   x_next;
    logic signed [X_W-1:0]   x_reg;
    logic signed [2*X_W-1:0] xx;

    logic signed [X_W-1:0]   x_pipe  [NS];
    logic [X2_W-1:0]         x2_pipe [NS];
    logic [T_W-1:0]          t_pipe  [TERMS+1];

    logic signed [X_W+T_W:0] prod_f;
    logic signed [SIN_W-1:0] sine_reg;

    // reduce into [-pi, pi)
    always_comb
    begin
        if (angle >= THREE_PI_Q30)
            offset = -FOUR_PI_Q30;
        else if (angle >= PI_Q30)
            offset = -TWO_PI_Q30;
        else if (angle < -THREE_PI_Q30)
            offset = FOUR_PI_Q30;
        else if (angle < -PI_Q30)
            offset = TWO_PI_Q30;
        else
            offset = '0;
        a_sum = angle + offset;
    end

    always_ff @(posedge clk)
    begin
        a_red_reg <= a_sum[RED_W-1:0];
    end

    // fold into [-pi/2, pi/2]
    always_comb
    begin
        if (a_red_reg > RED_W'(HALF_PI_Q30))
            x_next = RED_W'(PI_Q30) - a_red_reg;
        else if (a_red_reg < -RED_W'(HALF_PI_Q30))
            x_next = -RED_W'(PI_Q30) - a_red_reg;
        else
            x_next = a_red_reg;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    assign xx = x_reg * x_reg;

    always_ff @(posedge clk)
    begin
        x_pipe[0]  <= x_reg;
        x2_pipe[0] <= xx[30 +: X2_W];
    end

    generate
        for (genvar i = 0; i < TERMS; i++)
        begin : g_step
            localparam recip_t RC = TAYLOR_RECIP[i];
            localparam tdiv_t  DV = TAYLOR_DIV[i];

            logic [T_W-1:0]              t_in;
            logic [X2_W+T_W-1:0]         prod_a;
            logic [P_W-1:0]              p_reg;
            logic [P_W-1:0]              pb_reg;
            logic [P_W+RECIP_W-1:0]      prod_b;
            logic [QE_W-1:0]             qe_reg;
            logic [QE_W+DIV_W-1:0]       qd;
            logic [P_W-1:0]              rem;
            logic [QE_W-1:0]             q_fix;

            if (i == 0)
            begin : g_first
                assign t_in = Q30_ONE;
            end
            else
            begin : g_rest
                assign t_in = t_pipe[i];
            end

            assign prod_a = x2_pipe[3*i] * t_in;
            assign prod_b = p_reg * RC;
            assign qd     = qe_reg * DV;
            assign rem    = pb_reg - P_W'(qd);
            assign q_fix  = qe_reg + QE_W'(rem >= P_W'(DV));

            always_ff @(posedge clk)
            begin
                p_reg          <= prod_a[30 +: P_W];
                x_pipe[3*i+1]  <= x_pipe[3*i];
                x2_pipe[3*i+1] <= x2_pipe[3*i];

                qe_reg         <= prod_b[RECIP_SHIFT +: QE_W];
                pb_reg         <= p_reg;
                x_pipe[3*i+2]  <= x_pipe[3*i+1];
                x2_pipe[3*i+2] <= x2_pipe[3*i+1];

                t_pipe[i+1]    <= Q30_ONE - T_W'(q_fix);
                x_pipe[3*i+3]  <= x_pipe[3*i+2];
                x2_pipe[3*i+3] <= x2_pipe[3*i+2];
            end
        end
    endgenerate

    assign prod_f = x_pipe[NS-1] * $signed({1'b0, t_pipe[TERMS]});

    always_ff @(posedge clk)
    begin
        sine_reg <= prod_f[30 +: SIN_W];
    end

    assign sine = sine_reg;

endmodule

// File: hdl/acbp_front.sv
// ----------------------------------------------------------------------------
// acbp_front
// takes items, forms deltas and trig terms, numerator and denominator
// ----------------------------------------------------------------------------
module acbp_front #(
    parameter int COORD_WIDTH = acbp_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_WIDTH = acbp_pkg::DEF_ANGLE_WIDTH
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    input  logic signed [COORD_WIDTH-1:0]                     pose_x,
    input  logic signed [COORD_WIDTH-1:0]                     pose_y,
    input  logic signed [ANGLE_WIDTH-1:0]                     pose_heading,
    input  logic signed [COORD_WIDTH-1:0]                     target_x,
    input  logic signed [COORD_WIDTH-1:0]                     target_y,
    output logic                                              out_valid,
    output logic [acbp_pkg::SIN_W+COORD_WIDTH+1:0]            mag,
    output logic [2*COORD_WIDTH+2:0]                          den,
    output acbp_pkg::acbp_flags_t                             flags
);
    import acbp_pkg::*;

    localparam int DXW  = COORD_WIDTH + 1;
    localparam int PS_W = SIN_W + DXW;
    localparam int MW   = PS_W + 1;
    localparam int SQ_W = 2 * DXW;
    localparam int DW   = SQ_W + 1;
    localparam int KSH  = 30 - (ANGLE_WIDTH - 4);
    localparam int L    = SINE_LAT;

    logic signed [ANG_W-1:0] th;
    logic signed [ANG_W-1:0] th_s_reg;
    logic signed [ANG_W-1:0] th_c_reg;
    logic signed [DXW-1:0]   dx_reg;
    logic signed [DXW-1:0]   dy_reg;
    logic                    v1_reg;

    logic signed [DXW-1:0]   dx_dly [L];
    logic signed [DXW-1:0]   dy_dly [L];
    logic [L-1:0]            vd_reg;

    logic signed [SIN_W-1:0] s_val;
    logic signed [SIN_W-1:0] c_val;

    logic signed [PS_W-1:0]  ps_reg;
    logic signed [PS_W-1:0]  pc_reg;
    logic signed [SQ_W-1:0]  dxx_reg;
    logic signed [SQ_W-1:0]  dyy_reg;
    logic                    vp_reg;

    logic signed [MW-1:0]    n_reg;
    logic [DW-1:0]           d_reg;
    logic                    vn_reg;

    logic [MW-1:0]           mag_reg;
    logic [DW-1:0]           den_reg;
    acbp_flags_t             flags_reg;
    logic                    vm_reg;

    generate
        if (KSH >= 0)
        begin : g_shl
            assign th = ANG_W'(pose_heading) <<< KSH;
        end
        else
        begin : g_shr
            assign th = ANG_W'(pose_heading >>> (-KSH));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        th_s_reg <= th;
        th_c_reg <= th + HALF_PI_Q30;
        dx_reg   <= DXW'(target_x) - DXW'(pose_x);
        dy_reg   <= DXW'(target_y) - DXW'(pose_y);
    end

    acbp_sine u_sin (
        .clk   (clk),
        .angle (th_s_reg),
        .sine  (s_val)
    );

    acbp_sine u_cos (
        .clk   (clk),
        .angle (th_c_reg),
        .sine  (c_val)
    );

    always_ff @(posedge clk)
    begin
        dx_dly[0] <= dx_reg;
        dy_dly[0] <= dy_reg;
        for (int j = 1; j < L; j++)
        begin
            dx_dly[j] <= dx_dly[j-1];
            dy_dly[j] <= dy_dly[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ps_reg  <= PS_W'(s_val) * PS_W'(dx_dly[L-1]);
        pc_reg  <= PS_W'(c_val) * PS_W'(dy_dly[L-1]);
        dxx_reg <= SQ_W'(dx_dly[L-1]) * SQ_W'(dx_dly[L-1]);
        dyy_reg <= SQ_W'(dy_dly[L-1]) * SQ_W'(dy_dly[L-1]);
    end

    always_ff @(posedge clk)
    begin
        n_reg <= MW'(ps_reg) - MW'(pc_reg);
        d_reg <= DW'(unsigned'(dxx_reg)) + DW'(unsigned'(dyy_reg));
    end

    always_ff @(posedge clk)
    begin
        mag_reg              <= n_reg[MW-1] ? unsigned'(-n_reg) : unsigned'(n_reg);
        den_reg              <= d_reg;
        flags_reg.neg        <= n_reg[MW-1];
        flags_reg.coincident <= (d_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            vd_reg <= '0;
            vp_reg <= 1'b0;
            vn_reg <= 1'b0;
            vm_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            vd_reg <= {vd_reg[L-2:0], v1_reg};
            vp_reg <= vd_reg[L-1];
            vn_reg <= vp_reg;
            vm_reg <= vn_reg;
        end
    end

    assign out_valid = vm_reg;
    assign mag       = mag_reg;
    assign den       = den_reg;
    assign flags     = flags_reg;

endmodule

// File: hdl/acbp_queue.sv
// ----------------------------------------------------------------------------
// acbp_queue
// short fifo between the front and the back of the block
// ----------------------------------------------------------------------------
module acbp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = acbp_pkg::Q_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop_ready,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data,
    output logic             full
);
    import acbp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_pop;

    assign pop_valid = (count_reg != '0);
    assign do_pop    = pop_valid && pop_ready;
    assign pop_data  = mem[rd_ptr_reg];
    assign full      = (count_reg == CW'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/acbp_back.sv
// ----------------------------------------------------------------------------
// acbp_back
// rounded division pipeline, one quotient bit per stage, then saturation
// ----------------------------------------------------------------------------
module acbp_back #(
    parameter int COORD_WIDTH     = acbp_pkg::DEF_COORD_WIDTH,
    parameter int COORD_FRAC_BITS = acbp_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic [acbp_pkg::SIN_W+COORD_WIDTH+1:0]  mag,
    input  logic [2*COORD_WIDTH+2:0]                den,
    input  acbp_pkg::acbp_flags_t                   flags,
    output logic                                    done,
    output logic signed [COORD_WIDTH-1:0]           curvature,
    output logic                                    saturated,
    output logic                                    coincident
);
    import acbp_pkg::*;

    localparam int MW   = SIN_W + COORD_WIDTH + 2;
    localparam int DW   = 2 * COORD_WIDTH + 3;
    localparam int SH   = 2 * COORD_FRAC_BITS + 1 - 30;
    localparam int SHL  = (SH > 0) ? SH : 0;
    localparam int SHR  = (SH < 0) ? -SH : 0;
    localparam int NA   = MW + SHL + 1;
    localparam int NB   = DW + SHR;
    localparam int NW   = ((NA > NB) ? NA : NB) + 1;
    localparam int D2W  = DW + SHR + 1;
    localparam int QB   = COORD_WIDTH;
    localparam int RW   = (NW > D2W + QB) ? NW : D2W + QB;

    logic [RW-1:0]      r_pipe  [QB+1];
    logic [D2W-1:0]     d2_pipe [QB+1];
    logic [QB-1:0]      q_pipe  [QB+1];
    acbp_flags_t        f_pipe  [QB+1];
    logic               ovf_pipe [QB];
    logic [QB:0]        v_pipe;

    logic [QB-1:0]      limit;
    logic [QB-1:0]      q_fin;
    logic [QB-1:0]      q_sat;
    logic               sat;

    logic                          done_reg;
    logic signed [COORD_WIDTH-1:0] curv_reg;
    logic                          sat_reg;
    logic                          coinc_reg;

    always_ff @(posedge clk)
    begin
        r_pipe[0]  <= (RW'(mag) << (SHL + 1)) + (RW'(den) << SHR);
        d2_pipe[0] <= D2W'(den) << (SHR + 1);
        q_pipe[0]  <= '0;
        f_pipe[0]  <= flags;
    end

    generate
        for (genvar j = 0; j < QB; j++)
        begin : g_div
            localparam int B = QB - 1 - j;

            logic [RW-1:0] cmp;
            logic          take;

            assign cmp  = RW'(d2_pipe[j]) << B;
            assign take = (r_pipe[j] >= cmp);

            always_ff @(posedge clk)
            begin
                r_pipe[j+1]  <= take ? r_pipe[j] - cmp : r_pipe[j];
                q_pipe[j+1]  <= q_pipe[j] | (QB'(take) << B);
                d2_pipe[j+1] <= d2_pipe[j];
                f_pipe[j+1]  <= f_pipe[j];
            end

            if (j == 0)
            begin : g_ovf
                always_ff @(posedge clk)
                begin
                    ovf_pipe[0] <= (r_pipe[0] >= (RW'(d2_pipe[0]) << QB));
                end
            end
            else
            begin : g_ovf_pass
                always_ff @(posedge clk)
                begin
                    ovf_pipe[j] <= ovf_pipe[j-1];
                end
            end
        end
    endgenerate

    // clip to the signed output range
    always_comb
    begin
        q_fin = q_pipe[QB];
        limit = f_pipe[QB].neg ? (QB'(1) << (COORD_WIDTH - 1))
                               : (QB'(1) << (COORD_WIDTH - 1)) - 1'b1;
        sat   = ovf_pipe[QB-1] || (q_fin > limit);
        q_sat = sat ? limit : q_fin;
    end

    always_ff @(posedge clk)
    begin
        if (f_pipe[QB].coincident)
        begin
            curv_reg  <= '0;
            sat_reg   <= 1'b0;
            coinc_reg <= 1'b1;
        end
        else
        begin
            curv_reg  <= f_pipe[QB].neg ? signed'(-q_sat) : signed'(q_sat);
            sat_reg   <= sat;
            coinc_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_pipe   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_pipe   <= {v_pipe[QB-1:0], in_valid};
            done_reg <= v_pipe[QB];
        end
    end

    assign done       = done_reg;
    assign curvature  = curv_reg;
    assign saturated  = sat_reg;
    assign coincident = coinc_reg;

endmodule

// File: hdl/arc_curvature_between_poses_top.sv
// ----------------------------------------------------------------------------
// arc_curvature_between_poses_top
// signed curvature of the arc tangent to a pose heading through a target
// ----------------------------------------------------------------------------
// channel   direction  handshake          transfer when
// command   in         start / busy       start high and busy low at clk edge
// result    out        done strobe        done high for one cycle, no stall
//
// one item enters per cycle while busy is low; each result passes, in order, through
// an input register, the sine pipeline, 3 front stages, the queue, a divider input
// register, COORD_WIDTH division stages and an output register
// the division pipeline, one quotient bit per stage, sets the latency
// reset is asynchronous and clears only the valid chain and queue control
// the receiver cannot stall, so the queue drains every cycle and busy stays low
// ----------------------------------------------------------------------------
module arc_curvature_between_poses_top #(
    parameter int COORD_WIDTH     = acbp_pkg::DEF_COORD_WIDTH,
    parameter int COORD_FRAC_BITS = acbp_pkg::DEF_COORD_FRAC_BITS,
    parameter int ANGLE_WIDTH     = acbp_pkg::DEF_ANGLE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] pose_x,
    input  logic signed [COORD_WIDTH-1:0] pose_y,
    input  logic signed [ANGLE_WIDTH-1:0] pose_heading,
    input  logic signed [COORD_WIDTH-1:0] target_x,
    input  logic signed [COORD_WIDTH-1:0] target_y,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] curvature,
    output logic                          saturated,
    output logic                          coincident
);
    import acbp_pkg::*;

    localparam int MW = SIN_W + COORD_WIDTH + 2;
    localparam int DW = 2 * COORD_WIDTH + 3;
    localparam int FW = $bits(acbp_flags_t);
    localparam int QW = MW + DW + FW;

    logic              accept;
    logic              f_valid;
    logic [MW-1:0]     f_mag;
    logic [DW-1:0]     f_den;
    acbp_flags_t       f_flags;
    logic              q_valid;
    logic [QW-1:0]     q_data;
    logic              q_full;
    logic [MW-1:0]     b_mag;
    logic [DW-1:0]     b_den;
    acbp_flags_t       b_flags;

    assign busy   = q_full;
    assign accept = start && !busy;

    acbp_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .target_x     (target_x),
        .target_y     (target_y),
        .out_valid    (f_valid),
        .mag          (f_mag),
        .den          (f_den),
        .flags        (f_flags)
    );

    acbp_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data ({f_mag, f_den, f_flags}),
        .pop_ready (1'b1),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .full      (q_full)
    );

    assign {b_mag, b_den, b_flags} = q_data;

    acbp_back #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .mag        (b_mag),
        .den        (b_den),
        .flags      (b_flags),
        .done       (done),
        .curvature  (curvature),
        .saturated  (saturated),
        .coincident (coincident)
    );

endmodule

// File: test/tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checker
// watches the command and result transfers, predicts each curvature, compares
// ----------------------------------------------------------------------------
module tb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic signed [31:0] pose_heading,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic               done,
    input  logic signed [31:0] curvature,
    input  logic               saturated,
    input  logic               coincident,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [31:0] curv;
        logic        sat;
        logic        coin;
    } arc_result_t;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint ONE_Q30     = 64'sd1073741824;

    arc_result_t curv_queue[$];

    function automatic longint taylor_sine(longint a);
        longint divs[7];
        longint x;
        longint x2;
        longint t;
        divs = '{210, 156, 110, 72, 42, 20, 6};
        while (a >= PI_Q30) a -= TWO_PI_Q30;
        while (a < -PI_Q30) a += TWO_PI_Q30;
        if (a > HALF_PI_Q30)
            x = PI_Q30 - a;
        else if (a < -HALF_PI_Q30)
            x = -PI_Q30 - a;
        else
            x = a;
        x2 = (x * x) >>> 30;
        t = ONE_Q30;
        for (int i = 0; i < 7; i++)
            t = ONE_Q30 - ((x2 * t) >>> 30) / divs[i];
        return (x * t) >>> 30;
    endfunction

    function automatic arc_result_t predict_arc(longint px, longint py, longint hd,
                                                longint tx, longint ty);
        arc_result_t r;
        longint th;
        logic signed [127:0] sw, cw, dxw, dyw, num;
        logic [127:0] mag, den, quo, limit;
        logic neg;
        th = hd * 4;
        sw = taylor_sine(th);
        cw = taylor_sine(th + HALF_PI_Q30);
        dxw = tx - px;
        dyw = ty - py;
        num = sw * dxw - cw * dyw;
        neg = num < 0;
        mag = neg ? -num : num;
        den = dxw * dxw + dyw * dyw;
        r = '0;
        if (den == 0)
        begin
            r.coin = 1'b1;
            return r;
        end
        mag = mag << 3;
        quo = ((mag << 1) + den) / (den << 1);
        limit = (128'd1 << 31) - (neg ? 128'd0 : 128'd1);
        if (quo > limit)
        begin
            quo = limit;
            r.sat = 1'b1;
        end
        r.curv = neg ? 32'(-quo) : 32'(quo);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (start && !busy)
                curv_queue.push_back(predict_arc(pose_x, pose_y, pose_heading,
                                                 target_x, target_y));
            if (done)
            begin
                if (curv_queue.size() == 0)
                begin
                    $display("%0t: result with nothing expected: curvature %h", $time,
                             curvature);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    arc_result_t e;
                    e = curv_queue.pop_front();
                    if (curvature !== e.curv || saturated !== e.sat || coincident !== e.coin)
                    begin
                        $display("%0t: expected curv %h sat %b coin %b, got curv %h sat %b coin %b",
                                 $time, e.curv, e.sat, e.coin, curvature, saturated,
                                 coincident);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= curv_queue.size();
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// directed and random poses into the arc curvature block, verdict at the end
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     IDLE_LIMIT = 4000;
    localparam longint HDG_MAX    = 1686629713;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] pose_x, pose_y, pose_heading, target_x, target_y;
    logic               done;
    logic signed [31:0] curvature;
    logic               saturated;
    logic               coincident;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    int                 sender_idle;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    arc_curvature_between_poses_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .target_x     (target_x),
        .target_y     (target_y),
        .done         (done),
        .curvature    (curvature),
        .saturated    (saturated),
        .coincident   (coincident)
    );

    tb_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .target_x     (target_x),
        .target_y     (target_y),
        .done         (done),
        .curvature    (curvature),
        .saturated    (saturated),
        .coincident   (coincident),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] hd,
                             logic [31:0] tx, logic [31:0] ty);
        while ($urandom_range(99) < sender_idle)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        pose_x       <= px;
        pose_y       <= py;
        pose_heading <= hd;
        target_x     <= tx;
        target_y     <= ty;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_heading();
        return 32'(longint'($urandom_range(32'(2 * HDG_MAX))) - HDG_MAX);
    endfunction

    task automatic send_random();
        logic [31:0] px, py, tx, ty;
        int span;
        px = $urandom();
        py = $urandom();
        case ($urandom_range(3))
            0:
            begin
                tx = $urandom();
                ty = $urandom();
            end
            1:
            begin
                span = 1 << $urandom_range(24);
                tx = px + $urandom_range(2 * span) - span;
                ty = py + $urandom_range(2 * span) - span;
            end
            2:
            begin
                tx = px + $urandom_range(8) - 4;
                ty = py + $urandom_range(8) - 4;
            end
            default:
            begin
                tx = px;
                ty = ($urandom_range(3) == 0) ? py : py + $urandom_range(65536 * 16);
            end
        endcase
        send_pose(px, py, rand_heading(), tx, ty);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        pose_x       = '0;
        pose_y       = '0;
        pose_heading = '0;
        target_x     = '0;
        target_y     = '0;
        idle_cycles  = 0;
        sender_idle  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coincident points
        send_pose(32'h0001_0000, 32'h0002_0000, 32'd0, 32'h0001_0000, 32'h0002_0000);
        send_pose(32'h8000_0000, 32'h7fff_ffff, 32'(HDG_MAX), 32'h8000_0000, 32'h7fff_ffff);
        // straight ahead and behind
        send_pose(32'd0, 32'd0, 32'd0, 32'h0005_0000, 32'd0);
        send_pose(32'd0, 32'd0, 32'd0, -32'sh0005_0000, 32'd0);
        // headings at the range ends and at plus and minus a quarter turn
        send_pose(32'd0, 32'd0, 32'(HDG_MAX), 32'h0003_0000, 32'h0004_0000);
        send_pose(32'd0, 32'd0, 32'(-HDG_MAX), 32'h0003_0000, 32'h0004_0000);
        send_pose(32'd0, 32'd0, 32'd421657428, 32'h0001_0000, 32'h0001_0000);
        send_pose(32'd0, 32'd0, -32'sd421657428, 32'h0001_0000, 32'h0001_0000);
        // extreme coordinates
        send_pose(32'h8000_0000, 32'h8000_0000, 32'd0, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'(HDG_MAX), 32'h8000_0000, 32'h8000_0000);
        send_pose(32'hffff_ffff, 32'h0000_0000, 32'h8000_0000 + 32'd1, 32'h0, 32'hffff_ffff);
        // saturation both ways
        send_pose(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
        send_pose(32'd0, 32'd0, 32'd0, 32'd0, -32'sd1);
        send_pose(32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
        send_pose(32'd100, 32'd100, 32'd421657428, 32'd101, 32'd100);
        send_pose(32'd100, 32'd100, -32'sd421657428, 32'd101, 32'd100);
        // unit circle cases
        send_pose(32'd0, 32'd0, 32'd0, 32'h0001_0000, -32'sh0001_0000);
        send_pose(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000);

        sender_idle = 37;
        repeat (610) send_random();
        sender_idle = 76;
        repeat (610) send_random();
        sender_idle = 0;
        repeat (630) send_random();
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: arc_curvature_between_poses_top.f
hdl/acbp_pkg.sv
hdl/acbp_sine.sv
hdl/acbp_front.sv
hdl/acbp_queue.sv
hdl/acbp_back.sv
hdl/arc_curvature_between_poses_top.sv
test/tb_checker.sv
test/tb_top.sv
